FILE: design/ehmt_pkg.sv
// Shared types and codes for the event handler match table.
package ehmt_pkg;

    localparam int TYPE_W      = 8;
    localparam int RID_W       = 16;
    localparam int SLOT_W      = 5;
    localparam int REQ_W       = 2;
    localparam int KIND_W      = 2;
    localparam int DEPTH_DEF   = 32;
    localparam int S_DATA_W    = 24;
    localparam int S_USER_W    = 3;
    localparam int M_DATA_W    = 24;
    localparam int M_USER_W    = 3;

    localparam logic [REQ_W-1:0] REQ_REG_GLOBAL   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REG_RECEIVER = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DISPATCH     = 2'd2;

    localparam logic [KIND_W-1:0] KIND_REPLY   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MATCH   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOMATCH = 2'd2;

    typedef struct packed {
        logic [TYPE_W-1:0] etype;
        logic [RID_W-1:0]  rid;
    } entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        logic              rot;
    } row_ctrl_t;

endpackage

FILE: design/ehmt_cell.sv
// One table slot: holds an entry, loads on write, takes its neighbor's entry on rotate.
module ehmt_cell (
    input  logic            aclk,
    input  logic            load,
    input  ehmt_pkg::entry_t wr_entry,
    input  logic            shift,
    input  ehmt_pkg::entry_t nb_entry,
    output ehmt_pkg::entry_t entry
);
    import ehmt_pkg::*;

    entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            entry_reg <= wr_entry;
        end else if (shift) begin
            entry_reg <= nb_entry;
        end
    end

    assign entry = entry_reg;

endmodule

FILE: design/ehmt_row.sv
// Circular row of table cells; cell 0 is the head seen by the scanner.
module ehmt_row #(
    parameter int DEPTH = ehmt_pkg::DEPTH_DEF
) (
    input  logic               aclk,
    input  ehmt_pkg::row_ctrl_t ctrl,
    input  ehmt_pkg::entry_t    wr_entry,
    output ehmt_pkg::entry_t    head
);
    import ehmt_pkg::*;

    entry_t cell_q [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        ehmt_cell u_cell (
            .aclk     (aclk),
            .load     (ctrl.wr_en && (ctrl.wr_slot == SLOT_W'(i))),
            .wr_entry (wr_entry),
            .shift    (ctrl.rot),
            .nb_entry (cell_q[(i + 1) % DEPTH]),
            .entry    (cell_q[i])
        );
    end

    assign head = cell_q[0];

endmodule

FILE: design/event_handler_match_table.sv
// Event subscription match table: two append-only tables scanned by rotating cell rows.
// A registration is accepted and answered from the output register. A dispatch is accepted,
// then rotates each scanned row once around, one slot per cycle while the output is free:
// the receiver table for a directed event, global then receiver for a broadcast, then the final
// word is loaded; a stalled output pauses the scan. Each match word is held back until the next
// match or the end of the scan so the final one can carry tlast.
module event_handler_match_table #(
    parameter int TABLE_DEPTH = ehmt_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // etype[7:0], rid[23:8]
    input  logic [ehmt_pkg::S_DATA_W-1:0] s_tdata,
    // req_type[1:0], to_any[2]
    input  logic [ehmt_pkg::S_USER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // slot_index[4:0], matched_receiver[20:5], accepted[21], zero[23:22]
    output logic [ehmt_pkg::M_DATA_W-1:0] m_tdata,
    // result_kind[1:0], from_receiver_list[2]
    output logic [ehmt_pkg::M_USER_W-1:0] m_tuser,
    output logic                          m_tlast
);
    import ehmt_pkg::*;

    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(TABLE_DEPTH);
    localparam logic [SLOT_W-1:0] IDX_LAST  = SLOT_W'(TABLE_DEPTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic              phase_rx_reg, phase_rx_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              any_reg, any_next;
    logic [TYPE_W-1:0] key_type_reg, key_type_next;
    logic [RID_W-1:0]  key_id_reg, key_id_next;
    logic [FILL_W-1:0] gfill_reg, gfill_next;
    logic [FILL_W-1:0] rfill_reg, rfill_next;

    logic              pend_valid_reg, pend_valid_next;
    logic              pend_rx_reg, pend_rx_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;
    logic [RID_W-1:0]  pend_id_reg, pend_id_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [KIND_W-1:0] o_kind_reg, o_kind_next;
    logic              o_rx_reg, o_rx_next;
    logic [SLOT_W-1:0] o_slot_reg, o_slot_next;
    logic [RID_W-1:0]  o_id_reg, o_id_next;
    logic              o_acc_reg, o_acc_next;
    logic              o_last_reg, o_last_next;

    logic [REQ_W-1:0]  in_req;
    logic [TYPE_W-1:0] in_type;
    logic [RID_W-1:0]  in_rid;
    logic              in_any;
    logic              out_free;
    logic              accept;
    logic              step;
    logic              hit;
    logic [FILL_W-1:0] scan_fill;
    entry_t            head_g, head_r, head;
    entry_t            wr_entry;
    row_ctrl_t         ctrl_g, ctrl_r;

    assign in_req  = s_tuser[1:0];
    assign in_any  = s_tuser[2];
    assign in_type = s_tdata[7:0];
    assign in_rid  = s_tdata[23:8];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign step     = (state_reg == ST_SCAN) && out_free;

    assign head      = phase_rx_reg ? head_r : head_g;
    assign scan_fill = phase_rx_reg ? rfill_reg : gfill_reg;
    assign hit = (FILL_W'(idx_reg) < scan_fill) && (head.etype == key_type_reg) &&
                 (!phase_rx_reg || any_reg || (head.rid == key_id_reg));

    always_comb begin
        wr_entry.etype = in_type;
        wr_entry.rid   = (in_req == REQ_REG_RECEIVER) ? in_rid : '0;
        ctrl_g.wr_en   = accept && (in_req == REQ_REG_GLOBAL) && (gfill_reg < FILL_FULL);
        ctrl_g.wr_slot = SLOT_W'(gfill_reg);
        ctrl_g.rot     = step && !phase_rx_reg;
        ctrl_r.wr_en   = accept && (in_req == REQ_REG_RECEIVER) && (rfill_reg < FILL_FULL);
        ctrl_r.wr_slot = SLOT_W'(rfill_reg);
        ctrl_r.rot     = step && phase_rx_reg;
    end

    ehmt_row #(.DEPTH(TABLE_DEPTH)) u_row_global (
        .aclk     (aclk),
        .ctrl     (ctrl_g),
        .wr_entry (wr_entry),
        .head     (head_g)
    );

    ehmt_row #(.DEPTH(TABLE_DEPTH)) u_row_receiver (
        .aclk     (aclk),
        .ctrl     (ctrl_r),
        .wr_entry (wr_entry),
        .head     (head_r)
    );

    always_comb begin
        state_next      = state_reg;
        phase_rx_next   = phase_rx_reg;
        idx_next        = idx_reg;
        any_next        = any_reg;
        key_type_next   = key_type_reg;
        key_id_next     = key_id_reg;
        gfill_next      = gfill_reg;
        rfill_next      = rfill_reg;
        pend_valid_next = pend_valid_reg;
        pend_rx_next    = pend_rx_reg;
        pend_slot_next  = pend_slot_reg;
        pend_id_next    = pend_id_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        o_kind_next     = o_kind_reg;
        o_rx_next       = o_rx_reg;
        o_slot_next     = o_slot_reg;
        o_id_next       = o_id_reg;
        o_acc_next      = o_acc_reg;
        o_last_next     = o_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_req)
                        REQ_REG_GLOBAL: begin
                            m_tvalid_next = 1'b1;
                            o_kind_next   = KIND_REPLY;
                            o_rx_next     = 1'b0;
                            o_id_next     = '0;
                            o_last_next   = 1'b1;
                            if (gfill_reg < FILL_FULL) begin
                                o_slot_next = SLOT_W'(gfill_reg);
                                o_acc_next  = 1'b1;
                                gfill_next  = gfill_reg + 1'b1;
                            end else begin
                                o_slot_next = '0;
                                o_acc_next  = 1'b0;
                            end
                        end
                        REQ_REG_RECEIVER: begin
                            m_tvalid_next = 1'b1;
                            o_kind_next   = KIND_REPLY;
                            o_rx_next     = 1'b1;
                            o_id_next     = in_rid;
                            o_last_next   = 1'b1;
                            if (rfill_reg < FILL_FULL) begin
                                o_slot_next = SLOT_W'(rfill_reg);
                                o_acc_next  = 1'b1;
                                rfill_next  = rfill_reg + 1'b1;
                            end else begin
                                o_slot_next = '0;
                                o_acc_next  = 1'b0;
                            end
                        end
                        REQ_DISPATCH: begin
                            state_next      = ST_SCAN;
                            phase_rx_next   = !in_any;
                            idx_next        = '0;
                            any_next        = in_any;
                            key_type_next   = in_type;
                            key_id_next     = in_rid;
                            pend_valid_next = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (step) begin
                    if (hit) begin
                        if (pend_valid_reg) begin
                            m_tvalid_next = 1'b1;
                            o_kind_next   = KIND_MATCH;
                            o_rx_next     = pend_rx_reg;
                            o_slot_next   = pend_slot_reg;
                            o_id_next     = pend_id_reg;
                            o_acc_next    = 1'b0;
                            o_last_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_rx_next    = phase_rx_reg;
                        pend_slot_next  = idx_reg;
                        pend_id_next    = phase_rx_reg ? head.rid : '0;
                    end
                    if (idx_reg == IDX_LAST) begin
                        idx_next = '0;
                        if (phase_rx_reg) begin
                            state_next = ST_DONE;
                        end else begin
                            phase_rx_next = 1'b1;
                        end
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    o_acc_next      = 1'b0;
                    o_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                    if (pend_valid_reg) begin
                        o_kind_next = KIND_MATCH;
                        o_rx_next   = pend_rx_reg;
                        o_slot_next = pend_slot_reg;
                        o_id_next   = pend_id_reg;
                    end else begin
                        o_kind_next = KIND_NOMATCH;
                        o_rx_next   = 1'b0;
                        o_slot_next = '0;
                        o_id_next   = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_rx_reg   <= 1'b0;
            idx_reg        <= '0;
            gfill_reg      <= '0;
            rfill_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_rx_reg   <= phase_rx_next;
            idx_reg        <= idx_next;
            gfill_reg      <= gfill_next;
            rfill_reg      <= rfill_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        any_reg       <= any_next;
        key_type_reg  <= key_type_next;
        key_id_reg    <= key_id_next;
        pend_rx_reg   <= pend_rx_next;
        pend_slot_reg <= pend_slot_next;
        pend_id_reg   <= pend_id_next;
        o_kind_reg    <= o_kind_next;
        o_rx_reg      <= o_rx_next;
        o_slot_reg    <= o_slot_next;
        o_id_reg      <= o_id_next;
        o_acc_reg     <= o_acc_next;
        o_last_reg    <= o_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, o_acc_reg, o_id_reg, o_slot_reg};
    assign m_tuser  = {o_rx_reg, o_kind_reg};
    assign m_tlast  = o_last_reg;

    a_gfill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        gfill_reg <= FILL_FULL)
        else $error("global fill count past table depth");

    a_rfill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rfill_reg <= FILL_FULL)
        else $error("receiver fill count past table depth");

    a_global_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && !phase_rx_reg) |-> any_reg)
        else $error("global table scanned for a directed event");

    a_nomatch_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (o_kind_reg == KIND_NOMATCH || o_kind_reg == KIND_REPLY))
            |-> o_last_reg)
        else $error("single-word reply without last flag");

    a_done_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_tvalid_reg && o_last_reg))
        else $error("final word not sent at end of scan");

endmodule
